[src/md5de_pkg.sv]
package md5de_pkg;

    localparam logic [31:0] INIT_A   = 32'h67452301;
    localparam logic [31:0] INIT_B   = 32'hefcdab89;
    localparam logic [31:0] INIT_C   = 32'h98badcfe;
    localparam logic [31:0] INIT_D   = 32'h10325476;
    localparam logic [31:0] PAD_BYTE = 32'h0000_0080;
    localparam logic [5:0]  STEP_LAST = 6'h3f;
    localparam logic [3:0]  IDX_LEN_LO = 4'd14;
    localparam logic [3:0]  IDX_LEN_HI = 4'd15;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RUN,
        ST_FOLD,
        ST_DONE
    } md5de_state_t;

    typedef struct packed {
        logic       init;
        logic       load;
        logic       step;
        logic       fold;
        logic [5:0] idx;
    } md5de_core_ctrl_t;

    function automatic logic [31:0] step_const(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by a given step
    function automatic logic [3:0] msg_index(input logic [5:0] idx);
        logic [3:0] j;
        logic [3:0] g;
        j = idx[3:0];
        case (idx[5:4])
            2'd0:    g = j;
            2'd1:    g = 4'(j * 4'd5 + 4'd1);
            2'd2:    g = 4'(j * 4'd3 + 4'd5);
            2'd3:    g = 4'(j * 4'd7);
            default: g = j;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] mix_func(input logic [1:0] round,
                                             input logic [31:0] b,
                                             input logic [31:0] c,
                                             input logic [31:0] d);
        logic [31:0] f;
        case (round)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

[src/md5de_if.sv]
interface md5de_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic        last;
    logic [2:0]  last_bytes;

    modport source (output valid, output msg_word, output last, output last_bytes,
                    input ready);
    modport sink (input valid, input msg_word, input last, input last_bytes,
                  output ready);
endinterface

interface md5de_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;

    modport source (output valid, output digest_a, output digest_b, output digest_c,
                    output digest_d, input ready);
    modport sink (input valid, input digest_a, input digest_b, input digest_c,
                  input digest_d, output ready);
endinterface

[src/md5de_msgbuf.sv]
module md5de_msgbuf
    import md5de_pkg::*;
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [3:0]  wr_idx,
    input  logic [31:0] wr_data,
    input  logic [3:0]  rd_idx,
    output logic [31:0] rd_data
);

    logic [31:0] words_reg [16];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            words_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = words_reg[rd_idx];

endmodule

[src/md5de_core.sv]
module md5de_core
    import md5de_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  md5de_core_ctrl_t ctrl,
    input  logic [31:0]      msg,
    output logic [31:0]      chain_a,
    output logic [31:0]      chain_b,
    output logic [31:0]      chain_c,
    output logic [31:0]      chain_d
);

    logic [31:0] chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] sum;
    logic [63:0] rot_dbl;
    logic [31:0] b_new;

    // one MD5 step per cycle
    always_comb
    begin
        sum = a_reg + mix_func(ctrl.idx[5:4], b_reg, c_reg, d_reg)
              + step_const(ctrl.idx) + msg;
        rot_dbl = {sum, sum} << rot_amount(ctrl.idx);
        b_new = b_reg + rot_dbl[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_a_reg <= INIT_A;
            chain_b_reg <= INIT_B;
            chain_c_reg <= INIT_C;
            chain_d_reg <= INIT_D;
        end
        else if (ctrl.init)
        begin
            chain_a_reg <= INIT_A;
            chain_b_reg <= INIT_B;
            chain_c_reg <= INIT_C;
            chain_d_reg <= INIT_D;
        end
        else if (ctrl.fold)
        begin
            chain_a_reg <= chain_a_reg + a_reg;
            chain_b_reg <= chain_b_reg + b_reg;
            chain_c_reg <= chain_c_reg + c_reg;
            chain_d_reg <= chain_d_reg + d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= chain_a_reg;
            b_reg <= chain_b_reg;
            c_reg <= chain_c_reg;
            d_reg <= chain_d_reg;
        end
        else if (ctrl.step)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_new;
        end
    end

    assign chain_a = chain_a_reg;
    assign chain_b = chain_b_reg;
    assign chain_c = chain_c_reg;
    assign chain_d = chain_d_reg;

endmodule

[src/md5_digest_engine_unit.sv]
// MD5 digest engine.
// msg_in carries the message as 32-bit little-endian words, first byte in bits 7:0.
// The word with last set ends the message; last_bytes gives its valid bytes (0..4,
// larger values count as 4). digest_out carries one transfer per message: the four
// chaining words A..D of the final MD5 state.
// Every 16th word starts a compression on the single shared step unit: 64 MD5
// steps, then a fold of the result into the chaining value.
// After the last word the padding words are written one per cycle, pausing while a
// full block compresses; one or two compressions follow the last word.
// msg_in.ready is low while padding, compressing, folding or waiting to hand over
// the digest.
// If digest_out stalls, the digest waits in an output register and the next message
// is already taken; only a second digest waits for the first transfer to finish.
// Reset loads the MD5 initial values and clears the word and bit counters; the
// block buffer holds no reset value and every entry is written before it is read.
module md5_digest_engine_unit
    import md5de_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    md5de_msg_if.sink           msg_in,
    md5de_dig_if.source         digest_out
);

    md5de_state_t      state_reg, state_next;
    logic [3:0]        word_idx_reg, word_idx_next;
    logic [5:0]        step_reg, step_next;
    logic [63:0]       bit_count_reg, bit_count_next;
    logic              pad_reg, pad_next;
    logic              extra_reg, extra_next;
    logic              lo_done_reg, lo_done_next;
    logic              final_reg, final_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       dig_a_reg, dig_b_reg, dig_c_reg, dig_d_reg;

    logic              push_en;
    logic [31:0]       push_data;
    logic              dig_load;
    logic [2:0]        n_sat;
    logic [31:0]       keep_mask;
    logic [31:0]       pad_word;
    md5de_core_ctrl_t  core_ctrl;
    logic [31:0]       rd_data;
    logic [31:0]       chain_a, chain_b, chain_c, chain_d;

    md5de_msgbuf u_msgbuf (
        .clk     (clk),
        .wr_en   (push_en),
        .wr_idx  (word_idx_reg),
        .wr_data (push_data),
        .rd_idx  (msg_index(step_reg)),
        .rd_data (rd_data)
    );

    md5de_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (core_ctrl),
        .msg     (rd_data),
        .chain_a (chain_a),
        .chain_b (chain_b),
        .chain_c (chain_c),
        .chain_d (chain_d)
    );

    // mask off the bytes past the end and drop the pad marker right after them
    always_comb
    begin
        n_sat = (msg_in.last_bytes > FULL_BYTES) ? FULL_BYTES : msg_in.last_bytes;
        case (n_sat[1:0])
            2'd0:    begin keep_mask = 32'h0000_0000; pad_word = PAD_BYTE;       end
            2'd1:    begin keep_mask = 32'h0000_00ff; pad_word = PAD_BYTE << 8;  end
            2'd2:    begin keep_mask = 32'h0000_ffff; pad_word = PAD_BYTE << 16; end
            2'd3:    begin keep_mask = 32'h00ff_ffff; pad_word = PAD_BYTE << 24; end
            default: begin keep_mask = 32'h0000_0000; pad_word = PAD_BYTE;       end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        word_idx_next  = word_idx_reg;
        step_next      = step_reg;
        bit_count_next = bit_count_reg;
        pad_next       = pad_reg;
        extra_next     = extra_reg;
        lo_done_next   = lo_done_reg;
        final_next     = final_reg;
        push_en        = 1'b0;
        push_data      = 32'h0;
        dig_load       = 1'b0;
        core_ctrl      = '0;
        core_ctrl.idx  = step_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_in.valid)
                begin
                    push_en = 1'b1;
                    if (!msg_in.last)
                    begin
                        push_data      = msg_in.msg_word;
                        bit_count_next = bit_count_reg + 64'd32;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + {58'd0, n_sat, 3'd0};
                        pad_next       = 1'b1;
                        state_next     = ST_PAD;
                        if (n_sat == FULL_BYTES)
                        begin
                            push_data  = msg_in.msg_word;
                            extra_next = 1'b1;
                        end
                        else
                        begin
                            push_data = (msg_in.msg_word & keep_mask) | pad_word;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (extra_reg)
                begin
                    push_data  = PAD_BYTE;
                    extra_next = 1'b0;
                end
                else if (word_idx_reg == IDX_LEN_LO)
                begin
                    push_data    = bit_count_reg[31:0];
                    lo_done_next = 1'b1;
                end
                else if (word_idx_reg == IDX_LEN_HI && lo_done_reg)
                begin
                    push_data  = bit_count_reg[63:32];
                    final_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                core_ctrl.step = 1'b1;
                step_next      = step_reg + 6'd1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                core_ctrl.fold = 1'b1;
                if (final_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || digest_out.ready)
                begin
                    dig_load       = 1'b1;
                    core_ctrl.init = 1'b1;
                    bit_count_next = 64'd0;
                    pad_next       = 1'b0;
                    extra_next     = 1'b0;
                    lo_done_next   = 1'b0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a full buffer starts a compression
        if (push_en)
        begin
            word_idx_next = word_idx_reg + 4'd1;
            if (word_idx_reg == IDX_LEN_HI)
            begin
                core_ctrl.load = 1'b1;
                step_next      = 6'd0;
                state_next     = ST_RUN;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (digest_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (dig_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_idx_reg  <= 4'd0;
            step_reg      <= 6'd0;
            bit_count_reg <= 64'd0;
            pad_reg       <= 1'b0;
            extra_reg     <= 1'b0;
            lo_done_reg   <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_idx_reg  <= word_idx_next;
            step_reg      <= step_next;
            bit_count_reg <= bit_count_next;
            pad_reg       <= pad_next;
            extra_reg     <= extra_next;
            lo_done_reg   <= lo_done_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dig_load)
        begin
            dig_a_reg <= chain_a;
            dig_b_reg <= chain_b;
            dig_c_reg <= chain_c;
            dig_d_reg <= chain_d;
        end
    end

    assign msg_in.ready        = (state_reg == ST_IDLE);
    assign digest_out.valid    = out_valid_reg;
    assign digest_out.digest_a = dig_a_reg;
    assign digest_out.digest_b = dig_b_reg;
    assign digest_out.digest_c = dig_c_reg;
    assign digest_out.digest_d = dig_d_reg;

`ifndef SYNTH
    a_wrap_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        push_en && word_idx_reg == IDX_LEN_HI |=> state_reg == ST_RUN && step_reg == 6'd0)
        else $error("full block did not start a compression");

    a_fold_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && step_reg == STEP_LAST |=> state_reg == ST_FOLD)
        else $error("compression did not end after the last step");

    a_done_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> word_idx_reg == 4'd0 && lo_done_reg && !extra_reg)
        else $error("digest finished without a complete padded block");

    a_digest_only_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        dig_load |-> state_reg == ST_DONE && final_reg)
        else $error("digest captured outside the final block");
`endif

endmodule
